### design/wma_pkg.sv
// Shared types and constants for the waveform moving-average core.
// No dependencies; imported by every other design file.
package wma_pkg;

  localparam int SAMPLE_BITS   = 16;
  localparam int HW_BITS       = 4;
  localparam int CFG_DATA_BITS = 4;

  typedef enum logic [0:0] {
    REG_HALF_WINDOW = 1'b0,
    REG_WINDOW_KIND = 1'b1
  } cfg_idx_t;

  typedef enum logic [0:0] {
    WIN_CENTERED = 1'b0,
    WIN_TRAILING = 1'b1
  } win_kind_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          block_end;
  } wma_in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] smoothed;
    logic                          final_res;
  } wma_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_NEXT,
    S_SETUP,
    S_SUM,
    S_DLOAD,
    S_DIV,
    S_OUT
  } wma_state_t;

  typedef struct packed {
    logic accept;
    logic step;
    logic finish;
    logic setup;
    logic sum;
    logic div_load;
    logic div_step;
    logic load_out;
  } wma_cmd_t;

  typedef struct packed {
    logic emit;
    logic at_stop;
    logic avg;
    logic sum_last;
    logic div_last;
    logic out_free;
  } wma_stat_t;

endpackage

### design/waveform_moving_average_core.sv
// Top level of the waveform moving-average smoother.
// Depends on wma_pkg, wma_ctrl and wma_dp.
//
//   channel   handshake             payload
//   in_       in_valid / in_ready   in_data   (wma_in_t: sample, block_end)
//   out_      out_valid / out_ready out_data  (wma_out_t: smoothed, final_res)
//   cfg_      cfg_valid / cfg_ready cfg_index, cfg_data
//
// A sample that releases no result is taken straight from the idle state. Each released
// result then passes setup, output and next when passed through, and setup, sum, divider
// load, divide, output and next when averaged over 2R+1 entries centred or R+1 trailing:
// one history entry a cycle through the window adder, then one quotient bit a cycle in
// the divider. The next state closes the transfer before in_ready rises again.
// Reset is synchronous and active low; it clears the counts and restores the config defaults.
// A result waits in the output register; while out_ready is low the
// controller holds in its output state and in_ready stays low.
module waveform_moving_average_core import wma_pkg::*; #(
  parameter int MAX_HALF_WINDOW = 15
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  wma_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output wma_out_t out_data,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  input  cfg_idx_t cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  wma_cmd_t  cmd;
  wma_stat_t stat;

  // Controller: walks each released sample through setup, then sum and divide when averaged, then output
  wma_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath: history, counts, adder, divider and output register
  wma_dp #(
    .MAX_HALF_WINDOW (MAX_HALF_WINDOW)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cmd       (cmd),
    .stat      (stat)
  );

`ifndef NO_ASSERTIONS
  // A transfer that releases results must drop in_ready the next cycle
  a_busy_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept && stat.emit |=> !in_ready)
    else $error("in_ready stayed high after a releasing transfer");

  // Closing an item returns the controller to accepting samples
  a_ready_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> in_ready)
    else $error("in_ready low after item finished");

  // Never overwrite a result still waiting in the output register
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> stat.out_free)
    else $error("output register overwritten");

  // A loaded result is presented on the next cycle
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid)
    else $error("loaded result not presented");
`endif

endmodule

### design/wma_ctrl.sv
// Sequencing state machine of the moving-average core.
// Depends on wma_pkg for the state, command and status types.
module wma_ctrl import wma_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  wma_stat_t stat,
  output wma_cmd_t  cmd
);

  wma_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (stat.emit) begin
            state_nxt = S_NEXT;
          end
        end
      end
      S_NEXT: begin
        if (stat.at_stop) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end else begin
          cmd.step  = 1'b1;
          state_nxt = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = stat.avg ? S_SUM : S_OUT;
      end
      S_SUM: begin
        cmd.sum = 1'b1;
        if (stat.sum_last) begin
          state_nxt = S_DLOAD;
        end
      end
      S_DLOAD: begin
        cmd.div_load = 1'b1;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_NEXT;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

### design/wma_dp.sv
// Datapath: config registers, sample history shift line, window adder,
// bit-serial divider and output register. Depends on wma_pkg.
module wma_dp import wma_pkg::*; #(
  parameter int MAX_HALF_WINDOW = 15
) (
  input  logic         clk,
  input  logic         rst_n,
  input  wma_in_t      in_data,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  cfg_idx_t     cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  output logic         out_valid,
  input  logic         out_ready,
  output wma_out_t     out_data,
  input  wma_cmd_t     cmd,
  output wma_stat_t    stat
);

  localparam int HD  = 2 * MAX_HALF_WINDOW + 1;
  localparam int CW  = $clog2(HD + 1);
  localparam int IW  = $clog2(HD);
  localparam int SW  = SAMPLE_BITS + $clog2(HD);
  localparam int ITW = $clog2(SW);

  logic signed [SAMPLE_BITS-1:0] hist_r [HD];
  logic [HW_BITS-1:0] half_window_r;
  win_kind_t          kind_r;
  logic [CW-1:0]      seen_r, pend_r, d_r, cnt_r;
  logic               end_r, avg_r, neg_r, out_valid_r;
  logic [IW-1:0]      k_r;
  logic signed [SW-1:0] acc_r;
  logic [SW-1:0]      quo_r;
  logic [CW-1:0]      rem_r;
  logic [ITW-1:0]     it_r;
  wma_out_t           out_data_r;

  logic [CW-1:0] r, held, seen_inc, j, wid;
  logic [IW-1:0] lo;
  logic signed [SAMPLE_BITS-1:0] rd;
  logic [CW:0]   trial;
  logic          ge;
  logic [SW-1:0] qv;

  // Clamp the half window to what the history can hold
  always_comb begin
    if (32'(half_window_r) > 32'(MAX_HALF_WINDOW)) begin
      r = CW'(MAX_HALF_WINDOW);
    end else begin
      r = CW'(half_window_r);
    end
  end

  assign held     = pend_r + CW'(1);
  assign seen_inc = (seen_r < CW'(HD)) ? seen_r + CW'(1) : CW'(HD);
  assign j        = (seen_r >= d_r) ? seen_r - d_r : '0;
  assign wid      = (kind_r == WIN_TRAILING) ? r + CW'(1) : (r << 1) + CW'(1);
  assign lo       = (kind_r == WIN_TRAILING) ? IW'(d_r) : IW'(d_r - r);
  assign rd       = hist_r[k_r];
  assign trial    = {rem_r, quo_r[SW-1]};
  assign ge       = trial >= {1'b0, wid};
  assign qv       = neg_r ? (~quo_r + SW'(1)) : quo_r;

  always_comb begin
    stat.emit     = in_data.block_end || (held > r);
    stat.at_stop  = (d_r == (end_r ? CW'(0) : r));
    stat.avg      = (j >= r) && (d_r >= r);
    stat.sum_last = (cnt_r == CW'(1));
    stat.div_last = (it_r == ITW'(SW - 1));
    stat.out_free = !out_valid_r || out_ready;
  end

  // Configuration registers; always ready; the user is to write them between items, the block does not enforce it
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_window_r <= HW_BITS'(2);
      kind_r        <= WIN_CENTERED;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_HALF_WINDOW: half_window_r <= cfg_data[HW_BITS-1:0];
        REG_WINDOW_KIND: kind_r        <= win_kind_t'(cfg_data[0]);
        default: ;
      endcase
    end
  end

  // History shift line, newest at index 0
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      hist_r[0] <= in_data.sample;
      for (int i = 1; i < HD; i++) begin
        hist_r[i] <= hist_r[i-1];
      end
    end
  end

  // Block counters and emission index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
      pend_r <= '0;
      d_r    <= '0;
      end_r  <= 1'b0;
    end else if (cmd.accept) begin
      end_r <= in_data.block_end;
      if (stat.emit) begin
        d_r <= held;
      end else begin
        pend_r <= held;
        seen_r <= seen_inc;
      end
    end else if (cmd.step) begin
      d_r <= d_r - CW'(1);
    end else if (cmd.finish) begin
      if (end_r) begin
        seen_r <= '0;
        pend_r <= '0;
      end else begin
        pend_r <= r;
        seen_r <= seen_inc;
      end
    end
  end

  // Window walk and divider
  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      avg_r <= stat.avg;
      k_r   <= stat.avg ? lo : IW'(d_r);
      cnt_r <= wid;
      acc_r <= '0;
    end else if (cmd.sum) begin
      acc_r <= acc_r + {{(SW-SAMPLE_BITS){rd[SAMPLE_BITS-1]}}, rd};
      k_r   <= k_r + IW'(1);
      cnt_r <= cnt_r - CW'(1);
    end else if (cmd.div_load) begin
      neg_r <= acc_r[SW-1];
      quo_r <= acc_r[SW-1] ? (~acc_r + SW'(1)) : acc_r;
      rem_r <= '0;
      it_r  <= '0;
    end else if (cmd.div_step) begin
      rem_r <= ge ? CW'(trial - {1'b0, wid}) : trial[CW-1:0];
      quo_r <= {quo_r[SW-2:0], ge};
      it_r  <= it_r + ITW'(1);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r.smoothed  <= avg_r ? qv[SAMPLE_BITS-1:0] : rd;
      out_data_r.final_res <= end_r && (d_r == CW'(0));
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
